### sv/heading_angle_to_target_unit_defines.svh
// assertion macros shared by the heading angle rtl
// needs clk and rst_n in the scope where a macro is used
`ifndef HEADING_ANGLE_TO_TARGET_UNIT_DEFINES_SVH
`define HEADING_ANGLE_TO_TARGET_UNIT_DEFINES_SVH

// same-cycle implication, reset masks the check
`define HAT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define HAT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/hat_pkg.sv
// types, widths and the arctangent table of the heading angle unit
// no dependencies
package hat_pkg;

    // signed difference of two 16-bit points plus an 8-bit offset
    localparam int DIFF_W     = 18;
    localparam int MAG_W      = 17;
    // magnitudes are scaled by 2^24 before the rotations
    localparam int PRESCALE   = 24;
    // cordic x/y datapath, covers 2^41 times the cordic gain plus sign
    localparam int XY_W       = 45;
    // accumulated angle in 2^-32 turn, signed
    localparam int Z_W        = 34;
    localparam int Q_W        = 31;
    localparam int ANGLE_W    = 33;
    localparam int TABLE_LEN  = 24;
    localparam int OFFSET_W   = 8;
    localparam int COORD_W    = 16;
    localparam int HEADING_W  = 16;

    localparam logic [Q_W-1:0]     QUARTER_TURN = 31'h4000_0000;
    localparam logic [ANGLE_W-1:0] HALF_TURN    = 33'h0_8000_0000;
    localparam logic [ANGLE_W-1:0] FULL_TURN    = 33'h1_0000_0000;

    // register indexes of the configuration port
    localparam logic REG_AIM_OFFSET_X = 1'b0;
    localparam logic REG_AIM_OFFSET_Y = 1'b1;

    localparam logic [OFFSET_W-1:0] AIM_OFFSET_RESET = 8'd20;

    // round(atan(2^-i) / (2*pi) * 2^32)
    localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    typedef struct packed {
        logic coin;
        logic ax_zero;
        logic ay_zero;
        logic dx_neg;
        logic dy_neg;
    } hat_flags_t;

endpackage

### sv/heading_angle_to_target_unit.sv
// heading angle unit: direction from shooter to offset target as a binary angle
// registers from input to output beat: stage a, b, each rotation, c, output
// throughput one beat per cycle without stalls, one register stage per rotation
// every stage holds its beat under back-pressure and fills bubbles ahead of it
// rst_n is asynchronous: clears all valid bits and sets both offsets to 20
// depends on hat_pkg and heading_angle_to_target_unit_defines.svh
`include "heading_angle_to_target_unit_defines.svh"

module heading_angle_to_target_unit #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // shooter_x, shooter_y, target_x, target_y
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // heading
    output logic [0:0]  m_tuser    // coincident
);

    localparam int N = CORDIC_STAGES;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [hat_pkg::OFFSET_W-1:0] off_x_reg;
    logic [hat_pkg::OFFSET_W-1:0] off_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg <= hat_pkg::AIM_OFFSET_RESET;
            off_y_reg <= hat_pkg::AIM_OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                hat_pkg::REG_AIM_OFFSET_X: off_x_reg <= cfg_data;
                hat_pkg::REG_AIM_OFFSET_Y: off_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage enables: a stage loads when it is empty or its beat moves on
    // ------------------------------------------------------------------
    logic a_valid_reg;
    logic c_valid_reg;
    logic out_valid_reg;
    logic cv_reg [0:N];

    logic en_a;
    logic ce [0:N];
    logic en_c;
    logic en_o;

    assign en_o = !out_valid_reg || m_tready;
    assign en_c = !c_valid_reg || en_o;
    assign ce[N] = !cv_reg[N] || en_c;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_en
            assign ce[g] = !cv_reg[g] || ce[g+1];
        end
    endgenerate

    assign en_a     = !a_valid_reg || ce[0];
    assign s_tready = en_a;

    // ------------------------------------------------------------------
    // stage a: offset target minus shooter, exact in 18 bits
    // ------------------------------------------------------------------
    logic [hat_pkg::COORD_W-1:0] sx;
    logic [hat_pkg::COORD_W-1:0] sy;
    logic [hat_pkg::COORD_W-1:0] tx;
    logic [hat_pkg::COORD_W-1:0] ty;
    logic [hat_pkg::DIFF_W-1:0]  dx_next;
    logic [hat_pkg::DIFF_W-1:0]  dy_next;
    logic [hat_pkg::DIFF_W-1:0]  dx_reg;
    logic [hat_pkg::DIFF_W-1:0]  dy_reg;

    assign sx = s_tdata[15:0];
    assign sy = s_tdata[31:16];
    assign tx = s_tdata[47:32];
    assign ty = s_tdata[63:48];

    always_comb
    begin
        dx_next = {{2{tx[15]}}, tx} + {10'd0, off_x_reg} - {{2{sx[15]}}, sx};
        dy_next = {{2{ty[15]}}, ty} + {10'd0, off_y_reg} - {{2{sy[15]}}, sy};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en_a)
            a_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    // ------------------------------------------------------------------
    // stage b: magnitudes, axis flags, prescaled cordic start vector
    // ------------------------------------------------------------------
    logic signed [hat_pkg::XY_W-1:0] cx_reg [0:N];
    logic signed [hat_pkg::XY_W-1:0] cy_reg [0:N];
    logic signed [hat_pkg::Z_W-1:0]  cz_reg [0:N];
    hat_pkg::hat_flags_t             cf_reg [0:N];

    logic [hat_pkg::DIFF_W-1:0] adx;
    logic [hat_pkg::DIFF_W-1:0] ady;
    hat_pkg::hat_flags_t        b_flags;

    always_comb
    begin
        adx = dx_reg[hat_pkg::DIFF_W-1] ? (~dx_reg + 18'd1) : dx_reg;
        ady = dy_reg[hat_pkg::DIFF_W-1] ? (~dy_reg + 18'd1) : dy_reg;
        b_flags.ax_zero = (dx_reg == '0);
        b_flags.ay_zero = (dy_reg == '0);
        b_flags.coin    = b_flags.ax_zero && b_flags.ay_zero;
        b_flags.dx_neg  = dx_reg[hat_pkg::DIFF_W-1];
        b_flags.dy_neg  = dy_reg[hat_pkg::DIFF_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg[0] <= 1'b0;
        else if (ce[0])
            cv_reg[0] <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            cx_reg[0] <= hat_pkg::XY_W'(adx[hat_pkg::MAG_W-1:0]) << hat_pkg::PRESCALE;
            cy_reg[0] <= hat_pkg::XY_W'(ady[hat_pkg::MAG_W-1:0]) << hat_pkg::PRESCALE;
            cz_reg[0] <= '0;
            cf_reg[0] <= b_flags;
        end
    end

    // ------------------------------------------------------------------
    // cordic vectoring: one rotation per registered stage
    // rotation k drives y toward zero by the sign of y, shifts are floor
    // ------------------------------------------------------------------
    generate
        for (g = 0; g < N; g++)
        begin : g_rot
            logic signed [hat_pkg::XY_W-1:0] xs;
            logic signed [hat_pkg::XY_W-1:0] ys;
            logic signed [hat_pkg::Z_W-1:0]  step;

            assign xs   = cx_reg[g] >>> g;
            assign ys   = cy_reg[g] >>> g;
            assign step = hat_pkg::Z_W'(hat_pkg::ATAN_TURNS[g]);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    cv_reg[g+1] <= 1'b0;
                else if (ce[g+1])
                    cv_reg[g+1] <= cv_reg[g];
            end

            always_ff @(posedge clk)
            begin
                if (ce[g+1])
                begin
                    if (!cy_reg[g][hat_pkg::XY_W-1])
                    begin
                        cx_reg[g+1] <= cx_reg[g] + ys;
                        cy_reg[g+1] <= cy_reg[g] - xs;
                        cz_reg[g+1] <= cz_reg[g] + step;
                    end
                    else
                    begin
                        cx_reg[g+1] <= cx_reg[g] - ys;
                        cy_reg[g+1] <= cy_reg[g] + xs;
                        cz_reg[g+1] <= cz_reg[g] - step;
                    end
                    cf_reg[g+1] <= cf_reg[g];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // stage c: clamp to the first quadrant, axis overrides, quadrant fold
    // ------------------------------------------------------------------
    logic [hat_pkg::Q_W-1:0]      q;
    logic [hat_pkg::ANGLE_W-1:0]  angle_next;
    logic [hat_pkg::ANGLE_W-1:0]  c_angle_reg;
    hat_pkg::hat_flags_t          c_flags_reg;
    hat_pkg::hat_flags_t          zf;

    assign zf = cf_reg[N];

    always_comb
    begin
        priority if (zf.ay_zero)
            q = '0;
        else if (zf.ax_zero)
            q = hat_pkg::QUARTER_TURN;
        else if (cz_reg[N][hat_pkg::Z_W-1])
            q = '0;
        else if (cz_reg[N] > $signed({3'b000, hat_pkg::QUARTER_TURN}))
            q = hat_pkg::QUARTER_TURN;
        else
            q = cz_reg[N][hat_pkg::Q_W-1:0];

        // quadrant rules: x axis ties fold to 0 and half turn
        priority if (!zf.dy_neg && !zf.dx_neg)
            angle_next = {2'b00, q};
        else if (!zf.dy_neg)
            angle_next = hat_pkg::HALF_TURN - {2'b00, q};
        else if (zf.dx_neg || zf.ax_zero)
            angle_next = hat_pkg::HALF_TURN + {2'b00, q};
        else
            angle_next = hat_pkg::FULL_TURN - {2'b00, q};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en_c)
            c_valid_reg <= cv_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (en_c)
        begin
            c_angle_reg <= angle_next;
            c_flags_reg <= zf;
        end
    end

    // ------------------------------------------------------------------
    // output register: round half up to ANGLE_BITS, full turn wraps to 0
    // ------------------------------------------------------------------
    logic [hat_pkg::ANGLE_W:0]     rounded;
    logic [23:0]                   head_ext;
    logic [hat_pkg::HEADING_W-1:0] heading_next;
    logic [hat_pkg::HEADING_W-1:0] heading_reg;
    logic                          coin_reg;

    always_comb
    begin
        rounded  = {1'b0, c_angle_reg} + ((hat_pkg::ANGLE_W + 1)'(1) << (31 - ANGLE_BITS));
        head_ext = 24'(rounded[31 -: ANGLE_BITS]);
        heading_next = c_flags_reg.coin ? '0 : head_ext[hat_pkg::HEADING_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_o)
            out_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            heading_reg <= heading_next;
            coin_reg    <= c_flags_reg.coin;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = heading_reg;
    assign m_tuser[0] = coin_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `HAT_ASSERT_NXT(a_takes_beat, s_tvalid && s_tready, a_valid_reg,
        "accepted beat did not reach stage a")
    `HAT_ASSERT_IMP(b_coin_flags, cv_reg[0] && cf_reg[0].ax_zero && cf_reg[0].ay_zero,
        cf_reg[0].coin, "coincident flag missing for zero vector")
    `HAT_ASSERT_IMP(c_pos_x_axis,
        c_valid_reg && !c_flags_reg.coin && c_flags_reg.ay_zero && !c_flags_reg.dx_neg,
        c_angle_reg == '0, "positive x axis must give angle zero")
    `HAT_ASSERT_IMP(out_coin_zero, out_valid_reg && coin_reg, heading_reg == '0,
        "coincident result with nonzero heading")

endmodule

### tb/heading_angle_to_target_unit_checker.sv
// result checker for the heading angle unit: watches config, input and result beats
// predicts each heading in fixed point and compares it with the result stream
// depends on hat_pkg for the offset reset value and the register indexes
module heading_angle_to_target_unit_checker #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [0:0]  m_tuser,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import hat_pkg::*;

    localparam int     SCALE_SHIFT = 24;
    localparam int     STEP_COUNT  = 24;
    localparam longint QUARTER     = 64'h0_4000_0000;
    localparam longint HALF        = 64'h0_8000_0000;

    // rotation angles in 2^-32 turn
    localparam logic [31:0] ROT_STEP [STEP_COUNT] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    typedef struct packed {
        logic [15:0] heading;
        logic        coincident;
    } aim_result_t;

    aim_result_t aim_results [$];
    int          offset_x;
    int          offset_y;

    function automatic aim_result_t predict_aim(input logic [63:0] beat);
        logic signed [15:0] sx, sy, tx, ty;
        longint             dx, dy, ax, ay, x, y, z, xs, ys, q, angle, rounded;
        aim_result_t        r;
        sx = beat[15:0];
        sy = beat[31:16];
        tx = beat[47:32];
        ty = beat[63:48];
        dx = longint'(tx) + longint'(offset_x) - longint'(sx);
        dy = longint'(ty) + longint'(offset_y) - longint'(sy);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        r.heading    = '0;
        r.coincident = 1'b0;
        if (dx == 0 && dy == 0)
        begin
            r.coincident = 1'b1;
            return r;
        end
        if (ay == 0)
            q = 0;
        else if (ax == 0)
            q = QUARTER;
        else
        begin
            // vectoring rotations toward the x axis
            x = ax <<< SCALE_SHIFT;
            y = ay <<< SCALE_SHIFT;
            z = 0;
            for (int i = 0; i < CORDIC_STAGES && i < STEP_COUNT; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(ROT_STEP[i]);
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(ROT_STEP[i]);
                end
            end
            if (z < 0)
                z = 0;
            else if (z > QUARTER)
                z = QUARTER;
            q = z;
        end
        // fold the first-quadrant angle out to the full circle
        if (dy >= 0 && dx >= 0)
            angle = q;
        else if (dy >= 0)
            angle = HALF - q;
        else if (dx <= 0)
            angle = HALF + q;
        else
            angle = 2 * HALF - q;
        rounded = (angle + (longint'(1) <<< (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
        rounded = rounded & ((longint'(1) <<< ANGLE_BITS) - 1);
        r.heading = rounded[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch, %s: got %0d, want %0d", $time, what, got, want);
        fail_count = fail_count + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        aim_result_t want;
        if (!rst_n)
        begin
            offset_x   = AIM_OFFSET_RESET;
            offset_y   = AIM_OFFSET_RESET;
            fail_count = 0;
            aim_results.delete();
        end
        else
        begin
            // prediction uses the offsets in force before this edge's write
            if (s_tvalid && s_tready)
                aim_results.push_back(predict_aim(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (aim_results.size() == 0)
                    report_mismatch("result beat with nothing pending", m_tdata, -1);
                else
                begin
                    want = aim_results.pop_front();
                    if (m_tdata !== want.heading)
                        report_mismatch("heading", m_tdata, want.heading);
                    if (m_tuser[0] !== want.coincident)
                        report_mismatch("coincident", m_tuser[0], want.coincident);
                end
            end
            if (cfg_we)
            begin
                if (cfg_addr == REG_AIM_OFFSET_X)
                    offset_x = cfg_data;
                else if (cfg_addr == REG_AIM_OFFSET_Y)
                    offset_y = cfg_data;
            end
        end
        pending = aim_results.size();
    end

endmodule

### tb/heading_angle_to_target_unit_tb.sv
// top of the heading angle testbench: clock, reset, stimulus, back-pressure and verdict
// depends on hat_pkg, heading_angle_to_target_unit and heading_angle_to_target_unit_checker
module heading_angle_to_target_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hat_pkg::*;

    localparam int ANGLE_BITS      = 16;
    localparam int CORDIC_STAGES   = 16;
    // pipeline depth of the rtl register stages; the drain adds slack on top
    localparam int PIPE_LATENCY    = CORDIC_STAGES + 4;
    localparam int DRAIN_CYCLES    = 2 * PIPE_LATENCY;
    localparam int ITEMS_PER_PHASE = 200;
    // longest legal quiet stretch is a long sink stall plus the pipe, far below this
    localparam int WATCHDOG_LIMIT  = 5000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_addr;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // shooter_x, shooter_y, target_x, target_y
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // heading
    logic [0:0]  m_tuser;    // coincident

    int fail_count;
    int pending;
    int idle_cycles;

    // offsets currently loaded, used to aim random beats at special points
    int aim_x;
    int aim_y;

    // when set, that side runs without gaps for a while
    bit steady_source;
    bit steady_sink;
    int stall_left;

    heading_angle_to_target_unit #(
        .ANGLE_BITS    (ANGLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    heading_angle_to_target_unit_checker #(
        .ANGLE_BITS    (ANGLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // pack one aim request, shooter_x in the lowest bits
    function automatic logic [63:0] aim_beat(input int sx, input int sy, input int tx,
                                             input int ty);
        return {ty[15:0], tx[15:0], sy[15:0], sx[15:0]};
    endfunction

    // random request: half full-range coordinates, the rest placed so the
    // offset target lands near the shooter, on an axis, right on top of it or near vertical
    function automatic logic [63:0] random_request();
        int sx, sy, tx, ty, ddx, ddy, kind;
        sx   = $urandom_range(0, 65535);
        sy   = $urandom_range(0, 65535);
        tx   = $urandom_range(0, 65535);
        ty   = $urandom_range(0, 65535);
        kind = $urandom_range(0, 9);
        if (kind < 5)
        begin
            ddx = int'($urandom_range(0, 64)) - 32;
            ddy = int'($urandom_range(0, 64)) - 32;
            if (kind == 0)
                ddx = 0;
            else if (kind == 1)
                ddy = 0;
            else if (kind == 2)
            begin
                ddx = 0;
                ddy = 0;
            end
            else if (kind == 3)
                // near-vertical directions, dy about +-700 times dx, at a larger range
                ddy = (($urandom_range(0, 1) == 1) ? ddx : -ddx) * 700 + ddy;
            tx = sx + ddx - aim_x;
            ty = sy + ddy - aim_y;
        end
        return aim_beat(sx, sy, tx, ty);
    endfunction

    // drive one beat at the falling edge and hold it until the block takes it
    task automatic send_point(input logic [63:0] beat);
        int gap;
        gap = 0;
        if ($urandom_range(0, 127) == 0)
            steady_source = !steady_source;
        if (!steady_source && $urandom_range(0, 99) < 30)
            gap = idle_length();
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_point(random_request());
    endtask

    // new offsets only once the pipe has drained
    task automatic set_offsets(input logic [7:0] ox, input logic [7:0] oy);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY)
            @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_AIM_OFFSET_X;
        cfg_data <= ox;
        @(negedge clk);
        cfg_addr <= REG_AIM_OFFSET_Y;
        cfg_data <= oy;
        @(negedge clk);
        cfg_we   <= 1'b0;
        aim_x = ox;
        aim_y = oy;
    endtask

    // result side back-pressure, changed at the falling edge
    initial
    begin
        m_tready      = 1'b0;
        steady_sink   = 1'b0;
        stall_left    = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!steady_sink && $urandom_range(0, 99) < 15)
                    stall_left = idle_length();
            end
            if ($urandom_range(0, 255) == 0)
                steady_sink = !steady_sink;
        end
    end

    // watchdog: too long without any beat on either side ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL heading_angle_to_target_unit");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_AIM_OFFSET_X;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        steady_source = 1'b0;
        aim_x         = AIM_OFFSET_RESET;
        aim_y         = AIM_OFFSET_RESET;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed beats at the reset offsets of 20 on both axes
        // offset target on top of the shooter, middle and both extremes
        send_point(aim_beat(0, 0, -20, -20));
        send_point(aim_beat(32767, 32767, 32747, 32747));
        send_point(aim_beat(-32748, -32748, -32768, -32768));
        // the four half axes: 0, pi, pi/2, 3pi/2
        send_point(aim_beat(0, 0, 100, -20));
        send_point(aim_beat(0, 0, -120, -20));
        send_point(aim_beat(0, 0, -20, 100));
        send_point(aim_beat(0, 0, -20, -120));
        // exact diagonals in every quadrant
        send_point(aim_beat(0, 0, 80, 80));
        send_point(aim_beat(0, 0, -120, 80));
        send_point(aim_beat(0, 0, -120, -120));
        send_point(aim_beat(0, 0, 80, -120));
        // largest differences of either sign
        send_point(aim_beat(-32768, -32768, 32767, 32767));
        send_point(aim_beat(32767, 32767, -32768, -32768));
        send_point(aim_beat(32767, -32768, -32768, 32767));
        send_point(aim_beat(-32768, 32767, 32767, -32768));
        // one pixel off an axis at long range; just below the x axis rounds up
        // to a full turn and wraps to zero
        send_point(aim_beat(0, 0, 32767, -19));
        send_point(aim_beat(0, 0, 32767, -21));
        send_point(aim_beat(0, 0, -19, 32767));
        send_point(aim_beat(0, 0, -21, 32767));
        // all-ones and alternating bit patterns
        send_point(aim_beat(-1, -1, -1, -1));
        send_point(aim_beat(21845, -21846, -21846, 21845));
        send_point(aim_beat(-21846, 21845, 21845, -21846));

        send_random(ITEMS_PER_PHASE);

        // offset extremes, mixed corners, then two random settings
        set_offsets(8'd0, 8'd0);
        send_random(ITEMS_PER_PHASE);
        set_offsets(8'd255, 8'd255);
        send_random(ITEMS_PER_PHASE);
        set_offsets(8'd0, 8'd255);
        send_random(ITEMS_PER_PHASE);
        set_offsets(8'd255, 8'd0);
        send_random(ITEMS_PER_PHASE);
        set_offsets(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        send_random(ITEMS_PER_PHASE);
        set_offsets(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        send_random(ITEMS_PER_PHASE);

        // drain: every prediction met by a result beat, then a quiet stretch for stray beats
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        if (fail_count == 0)
            $display("PASS heading_angle_to_target_unit");
        else
            $display("FAIL heading_angle_to_target_unit");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/hat_pkg.sv
sv/heading_angle_to_target_unit.sv
tb/heading_angle_to_target_unit_checker.sv
tb/heading_angle_to_target_unit_tb.sv
